[design/lru_pkg.sv]
// Package: shared types and constants for the LRU page replacement block.
`default_nettype none

package lru_pkg;

	localparam int CFG_W   = 4;
	localparam int FAULT_W = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic match;
		logic take;
	} cmp_res_t;

endpackage

`default_nettype wire

[design/lru_cmp_unit.sv]
// Shared compare unit: page match and minimum-stamp test for one frame entry.
`default_nettype none

module lru_cmp_unit #(
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32
) (
	input  wire logic [PAGE_BITS-1:0]  pg,
	input  wire logic                  e_valid,
	input  wire logic [PAGE_BITS-1:0]  e_page,
	input  wire logic [STAMP_BITS-1:0] e_stamp,
	input  wire logic [STAMP_BITS-1:0] min_stamp,
	input  wire logic                  first,
	output lru_pkg::cmp_res_t          res
);

	always_comb begin
		res.match = e_valid && (e_page == pg);
		res.take  = first || (e_stamp < min_stamp);
	end

endmodule

`default_nettype wire

[design/lru_frame_store.sv]
// Frame store: page/stamp memory with per-frame valid flops.
`default_nettype none

module lru_frame_store #(
	parameter int DEPTH      = 8,
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32,
	parameter int IDX_W      = 3
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IDX_W-1:0]      rd_addr,
	output logic                       rd_valid,
	output logic [PAGE_BITS-1:0]       rd_page,
	output logic [STAMP_BITS-1:0]      rd_stamp,
	input  wire logic                  wr_en,
	input  wire logic [IDX_W-1:0]      wr_addr,
	input  wire logic [PAGE_BITS-1:0]  wr_page,
	input  wire logic [STAMP_BITS-1:0] wr_stamp
);

	localparam int WORD_W = PAGE_BITS + STAMP_BITS;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] rd_word_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_page, wr_stamp};
		end
		rd_word_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// never-written frames read as zero
	always_comb begin
		rd_valid = rd_valid_q;
		rd_page  = rd_valid_q ? rd_word_q[WORD_W-1:STAMP_BITS] : '0;
		rd_stamp = rd_valid_q ? rd_word_q[STAMP_BITS-1:0] : '0;
	end

endmodule

`default_nettype wire

[design/lru_page_replacement_top.sv]
// Top level: LRU page replacement with per-frame last-use timestamps.
// Flow: accept in idle, then a scan of the active frames one by one, then an update state
//   that waits on the output handshake before the result is registered.
// A new request is accepted only in idle, once the previous one has committed its result.
// Reset clears frame valid flops, reference clock, fault counter; frames_in_use = 8.
`default_nettype none

module lru_page_replacement_top #(
	parameter int MAX_FRAMES = 8,
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lru_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [PAGE_BITS-1:0]          page,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               hit,
	output logic [$clog2((MAX_FRAMES > 1) ? MAX_FRAMES : 2)-1:0] frame_index,
	output logic                               evicted_valid,
	output logic [PAGE_BITS-1:0]               evicted_page,
	output logic [lru_pkg::FAULT_W-1:0]        fault_total
);

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int CW    = (CNT_W > lru_pkg::CFG_W) ? CNT_W : lru_pkg::CFG_W;

	lru_pkg::state_t state_q, state_d;

	logic [lru_pkg::CFG_W-1:0]   cfg_q;
	logic [STAMP_BITS-1:0]       ref_clk_q;
	logic [lru_pkg::FAULT_W-1:0] fault_q;
	logic [PAGE_BITS-1:0]        pg_q;
	logic [IDX_W-1:0]            last_q;
	logic [IDX_W:0]              idx_q;
	logic                        dv_q;
	logic [IDX_W-1:0]            dk_q;
	logic                        found_q;
	logic [IDX_W-1:0]            pick_q;
	logic [STAMP_BITS-1:0]       min_stamp_q;
	logic [IDX_W-1:0]            min_idx_q;
	logic [PAGE_BITS-1:0]        min_page_q;
	logic                        min_valid_q;
	logic                        out_valid_q;
	logic                        hit_q;
	logic [IDX_W-1:0]            frame_index_q;
	logic                        evicted_valid_q;
	logic [PAGE_BITS-1:0]        evicted_page_q;

	logic                  accept;
	logic                  commit;
	logic                  issue_en;
	logic [CW-1:0]         cfg_ext;
	logic [CW-1:0]         n_act;
	logic [IDX_W-1:0]      last_idx;
	logic [IDX_W-1:0]      rd_addr;
	logic                  rd_valid;
	logic [PAGE_BITS-1:0]  rd_page;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [PAGE_BITS-1:0]  wr_page;
	logic [STAMP_BITS-1:0] wr_stamp;
	lru_pkg::cmp_res_t     cmp;

	// active frame count, clamped to 1..MAX_FRAMES
	always_comb begin
		cfg_ext = CW'(cfg_q);
		if (cfg_ext == '0) begin
			n_act = CW'(1);
		end else if (cfg_ext > CW'(MAX_FRAMES)) begin
			n_act = CW'(MAX_FRAMES);
		end else begin
			n_act = cfg_ext;
		end
		last_idx = IDX_W'(n_act - CW'(1));
	end

	lru_frame_store #(
		.DEPTH     (MAX_FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.STAMP_BITS(STAMP_BITS),
		.IDX_W     (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_valid(rd_valid),
		.rd_page (rd_page),
		.rd_stamp(rd_stamp),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_page (wr_page),
		.wr_stamp(wr_stamp)
	);

	lru_cmp_unit #(
		.PAGE_BITS (PAGE_BITS),
		.STAMP_BITS(STAMP_BITS)
	) u_cmp (
		.pg       (pg_q),
		.e_valid  (rd_valid),
		.e_page   (rd_page),
		.e_stamp  (rd_stamp),
		.min_stamp(min_stamp_q),
		.first    (dk_q == '0),
		.res      (cmp)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lru_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lru_pkg::ST_SCAN;
				end
			end
			lru_pkg::ST_SCAN: begin
				if (dv_q && (dk_q == last_q)) begin
					state_d = lru_pkg::ST_UPDATE;
				end
			end
			lru_pkg::ST_UPDATE: begin
				if (commit) begin
					state_d = lru_pkg::ST_IDLE;
				end
			end
			default: state_d = lru_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		commit   = 1'b0;
		issue_en = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = dk_q;
		wr_page  = rd_page;
		wr_stamp = ref_clk_q;
		case (state_q)
			lru_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			lru_pkg::ST_SCAN: begin
				issue_en = (idx_q <= {1'b0, last_q});
				rd_addr  = idx_q[IDX_W-1:0];
				wr_en    = dv_q && cmp.match;
			end
			lru_pkg::ST_UPDATE: begin
				commit  = !out_valid_q || out_ready;
				wr_en   = commit && !found_q;
				wr_addr = min_idx_q;
				wr_page = pg_q;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lru_pkg::ST_IDLE;
			cfg_q       <= lru_pkg::CFG_RESET;
			ref_clk_q   <= '0;
			fault_q     <= '0;
			idx_q       <= '0;
			dv_q        <= 1'b0;
			dk_q        <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (accept) begin
				if (ref_clk_q != '1) begin
					ref_clk_q <= ref_clk_q + {{(STAMP_BITS-1){1'b0}}, 1'b1};
				end
				idx_q   <= {{IDX_W{1'b0}}, 1'b1};
				dv_q    <= 1'b1;
				dk_q    <= '0;
				found_q <= 1'b0;
			end else if (state_q == lru_pkg::ST_SCAN) begin
				dv_q <= issue_en;
				dk_q <= idx_q[IDX_W-1:0];
				if (issue_en) begin
					idx_q <= idx_q + {{IDX_W{1'b0}}, 1'b1};
				end
				if (dv_q && cmp.match) begin
					found_q <= 1'b1;
				end
			end else begin
				dv_q <= 1'b0;
			end
			if (commit && !found_q && (fault_q != '1)) begin
				fault_q <= fault_q + {{(lru_pkg::FAULT_W-1){1'b0}}, 1'b1};
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pg_q   <= page;
			last_q <= last_idx;
		end
		if ((state_q == lru_pkg::ST_SCAN) && dv_q) begin
			if (cmp.match && !found_q) begin
				pick_q <= dk_q;
			end
			if (cmp.take) begin
				min_stamp_q <= rd_stamp;
				min_idx_q   <= dk_q;
				min_page_q  <= rd_page;
				min_valid_q <= rd_valid;
			end
		end
		if (commit) begin
			hit_q           <= found_q;
			frame_index_q   <= found_q ? pick_q : min_idx_q;
			evicted_valid_q <= !found_q && min_valid_q;
			evicted_page_q  <= (!found_q && min_valid_q) ? min_page_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = fault_q;

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted_valid && (evicted_page == '0))
		else $error("hit transaction reports an eviction");

	a_fault_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> fault_q >= $past(fault_q))
		else $error("fault counter decreased");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == lru_pkg::ST_SCAN) || (state_q == lru_pkg::ST_UPDATE))
		else $error("frame store written outside scan or update");

	a_stamp_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lru_pkg::ST_SCAN |-> ref_clk_q != '0)
		else $error("zero reference stamp during scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lru_pkg::ST_SCAN) && dv_q |-> dk_q <= last_q)
		else $error("scan ran past the active frames");

endmodule

`default_nettype wire

[verif/lru_checker.sv]
// Checker: predicts LRU page replacement results and compares each output transaction.
`timescale 1ns / 1ps
`default_nettype none

module lru_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [lru_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [15:0]                   page,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic                          hit,
	input  wire logic [2:0]                    frame_index,
	input  wire logic                          evicted_valid,
	input  wire logic [15:0]                   evicted_page,
	input  wire logic [lru_pkg::FAULT_W-1:0]   fault_total,
	output int                                 errors,
	output int                                 pending,
	output int                                 results,
	output int                                 hits
);

	localparam int SLOTS = 8;

	typedef struct packed {
		logic                        hit;
		logic [2:0]                  frame;
		logic                        ev_valid;
		logic [15:0]                 ev_page;
		logic [lru_pkg::FAULT_W-1:0] faults;
	} lookup_t;

	logic [lru_pkg::CFG_W-1:0]   active_cfg;
	logic                        slot_used [SLOTS];
	logic [15:0]                 slot_page [SLOTS];
	logic [31:0]                 slot_age  [SLOTS];
	logic [31:0]                 use_clock;
	logic [lru_pkg::FAULT_W-1:0] fault_cnt;

	lookup_t lookups_due[$];
	lookup_t due;
	int      err_n;
	int      res_n;
	int      hit_n;

	function automatic lookup_t predict_lookup(input logic [15:0] pg);
		int      n;
		int      k;
		int      pick;
		logic    found;
		lookup_t r;
		n = (active_cfg == 0) ? 1 : (active_cfg > SLOTS) ? SLOTS : int'(active_cfg);
		if (use_clock != '1)
			use_clock = use_clock + 1;
		found = 1'b0;
		pick  = 0;
		for (k = 0; k < n; k++) begin
			if (slot_used[k] && slot_page[k] == pg) begin
				slot_age[k] = use_clock;
				if (!found)
					pick = k;
				found = 1'b1;
			end
		end
		r = '0;
		if (!found) begin
			pick = 0;
			for (k = 1; k < n; k++) begin
				if (slot_age[k] < slot_age[pick])
					pick = k;
			end
			if (slot_used[pick]) begin
				r.ev_valid = 1'b1;
				r.ev_page  = slot_page[pick];
			end
			slot_used[pick] = 1'b1;
			slot_page[pick] = pg;
			slot_age[pick]  = use_clock;
			if (fault_cnt != '1)
				fault_cnt = fault_cnt + 1;
		end
		r.hit    = found;
		r.frame  = pick[2:0];
		r.faults = fault_cnt;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			err_n++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_cfg = lru_pkg::CFG_RESET;
			for (int k = 0; k < SLOTS; k++) begin
				slot_used[k] = 1'b0;
				slot_page[k] = '0;
				slot_age[k]  = '0;
			end
			use_clock = '0;
			fault_cnt = '0;
			lookups_due.delete();
			err_n = 0;
			res_n = 0;
			hit_n = 0;
			errors  <= 0;
			pending <= 0;
			results <= 0;
			hits    <= 0;
		end else begin
			if (cfg_we)
				active_cfg = cfg_wdata;
			if (out_valid && out_ready) begin
				if (lookups_due.size() == 0) begin
					$display("%0t: unexpected transaction: expected none, actual frame %0d",
						$time, frame_index);
					err_n++;
				end else begin
					due = lookups_due.pop_front();
					check_field("hit", due.hit, hit);
					check_field("frame_index", due.frame, frame_index);
					check_field("evicted_valid", due.ev_valid, evicted_valid);
					check_field("evicted_page", due.ev_page, evicted_page);
					check_field("fault_total", due.faults, fault_total);
					res_n++;
					if (due.hit)
						hit_n++;
				end
			end
			if (in_valid && in_ready)
				lookups_due.push_back(predict_lookup(page));
			errors  <= err_n;
			pending <= lookups_due.size();
			results <= res_n;
			hits    <= hit_n;
		end
	end

endmodule

`default_nettype wire

[verif/testbench.sv]
// Testbench top: drives page references and frame settings, reports the verdict.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

	localparam int LIMIT = 400000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [lru_pkg::CFG_W-1:0]     cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic [15:0]                   page;
	logic                          out_valid;
	logic                          out_ready;
	logic                          hit;
	logic [2:0]                    frame_index;
	logic                          evicted_valid;
	logic [15:0]                   evicted_page;
	logic [lru_pkg::FAULT_W-1:0]   fault_total;

	int errors;
	int pending;
	int results;
	int hits;
	int cycles = 0;
	int sent;
	int settings;
	int gap_pct;
	logic calm;

	logic [15:0] pool [16];
	logic [3:0]  phase_cfg [9] = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd9, 4'd2, 4'd8};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lru_page_replacement_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.page          (page),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

	lru_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.page          (page),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total),
		.errors        (errors),
		.pending       (pending),
		.results       (results),
		.hits          (hits)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic push_page(input logic [15:0] pg);
		in_valid <= 1'b1;
		page     <= pg;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		if (!calm && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_frames(input logic [3:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings++;
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!calm) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
	end

	initial begin
		int n;
		int pool_n;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		page      = '0;
		sent      = 0;
		settings  = 1;
		gap_pct   = 30;
		calm      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill all eight frames, hit, then evict the least recent
		push_page(16'h0000);
		push_page(16'hFFFF);
		push_page(16'h0000);
		push_page(16'h1234);
		push_page(16'hAAAA);
		push_page(16'h5555);
		push_page(16'h0001);
		push_page(16'h8000);
		push_page(16'h7FFF);
		push_page(16'hFFFF);
		push_page(16'h4321);
		// zero acts as one frame; page held outside the range misses
		write_frames(4'd0);
		push_page(16'h7FFF);
		push_page(16'h7FFF);
		write_frames(4'd2);
		push_page(16'h5555);
		push_page(16'h5555);
		// above range acts as eight: duplicate residents hit together
		write_frames(4'd15);
		push_page(16'h5555);
		push_page(16'h7FFF);
		push_page(16'h0003);
		write_frames(4'd1);
		push_page(16'h0004);
		push_page(16'h0004);
		push_page(16'hFFFF);

		for (int ph = 0; ph < 9; ph++) begin
			write_frames(phase_cfg[ph]);
			calm = (ph == 8);
			case ($urandom_range(2))
				0: gap_pct = 0;
				1: gap_pct = 25;
				default: gap_pct = 60;
			endcase
			n = (phase_cfg[ph] == 0) ? 1 : (phase_cfg[ph] > 8) ? 8 : phase_cfg[ph];
			pool_n = n + $urandom_range(1, 4);
			for (int k = 0; k < pool_n; k++)
				pool[k] = 16'($urandom_range(0, 65535));
			pool[0] = (ph % 2 == 0) ? 16'h0000 : 16'hFFFF;
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(99) < 80)
					push_page(pool[4'($urandom_range(0, pool_n - 1))]);
				else
					push_page(16'($urandom));
			end
		end

		drain();
		$display("covered %0d page references across %0d frame settings", sent, settings);
		$display("checked %0d results: %0d hits, %0d faults", results, hits, results - hits);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
design/lru_pkg.sv
design/lru_cmp_unit.sv
design/lru_frame_store.sv
design/lru_page_replacement_top.sv
verif/lru_checker.sv
verif/testbench.sv
